FILE: rtl/mdca_pkg.sv
package mdca_pkg;

	// Primary opcodes
	localparam logic [5:0] OP_RTYPE = 6'h00;
	localparam logic [5:0] OP_J     = 6'h02;
	localparam logic [5:0] OP_JAL   = 6'h03;
	localparam logic [5:0] OP_BEQ   = 6'h04;
	localparam logic [5:0] OP_BNE   = 6'h05;
	localparam logic [5:0] OP_ADDI  = 6'h08;
	localparam logic [5:0] OP_ADDIU = 6'h09;
	localparam logic [5:0] OP_SLTI  = 6'h0A;
	localparam logic [5:0] OP_ANDI  = 6'h0C;
	localparam logic [5:0] OP_ORI   = 6'h0D;
	localparam logic [5:0] OP_XORI  = 6'h0E;
	localparam logic [5:0] OP_LUI   = 6'h0F;
	localparam logic [5:0] OP_LW    = 6'h23;
	localparam logic [5:0] OP_SW    = 6'h2B;

	// R-type function codes
	localparam logic [5:0] FN_SLL  = 6'h00;
	localparam logic [5:0] FN_SRL  = 6'h02;
	localparam logic [5:0] FN_SRA  = 6'h03;
	localparam logic [5:0] FN_JR   = 6'h08;
	localparam logic [5:0] FN_ADD  = 6'h20;
	localparam logic [5:0] FN_ADDU = 6'h21;
	localparam logic [5:0] FN_SUB  = 6'h22;
	localparam logic [5:0] FN_SUBU = 6'h23;
	localparam logic [5:0] FN_AND  = 6'h24;
	localparam logic [5:0] FN_OR   = 6'h25;
	localparam logic [5:0] FN_XOR  = 6'h26;
	localparam logic [5:0] FN_NOR  = 6'h27;
	localparam logic [5:0] FN_SLT  = 6'h2A;

	localparam logic [4:0]  LINK_REG    = 5'd31;
	localparam logic [31:0] REGION_MASK = 32'hF000_0000;

	typedef enum logic [1:0] {
		JK_NONE = 2'd0,
		JK_ABS  = 2'd1,
		JK_REG  = 2'd2
	} jump_kind_t;

	typedef enum logic [3:0] {
		ALU_ZERO,
		ALU_ADD,
		ALU_SUB,
		ALU_AND,
		ALU_OR,
		ALU_XOR,
		ALU_NOR,
		ALU_SLT,
		ALU_SLL,
		ALU_SRL,
		ALU_SRA,
		ALU_LUI
	} alu_op_t;

	typedef enum logic [1:0] {
		BSEL_REG,
		BSEL_SIMM,
		BSEL_ZIMM
	} bsel_t;

	// Decoded control handed from the decoder to the execute logic
	typedef struct packed {
		alu_op_t    alu_op;
		bsel_t      bsel;
		logic       is_branch;
		logic       branch_ne;
		jump_kind_t jump_kind;
		logic [4:0] dest_reg;
		logic       reg_write;
		logic       mem_read;
		logic       mem_write;
		logic       mem_to_reg;
		logic       link_to_reg;
	} ctrl_t;

endpackage

FILE: rtl/mdca_decoder.sv
module mdca_decoder import mdca_pkg::*; (
	input  logic [31:0] instruction,
	output ctrl_t       ctrl
);

	logic [5:0] op;
	logic [5:0] funct;
	logic [4:0] rt;
	logic [4:0] rd;

	assign op    = instruction[31:26];
	assign funct = instruction[5:0];
	assign rt    = instruction[20:16];
	assign rd    = instruction[15:11];

	// Main decoder
	always_comb begin
		ctrl = '{alu_op: ALU_ZERO, bsel: BSEL_REG, is_branch: 1'b0, branch_ne: 1'b0,
			jump_kind: JK_NONE, dest_reg: rt, reg_write: 1'b0, mem_read: 1'b0,
			mem_write: 1'b0, mem_to_reg: 1'b0, link_to_reg: 1'b0};
		unique case (op) inside
			OP_RTYPE: begin
				ctrl.dest_reg = rd;
				if (funct == FN_JR) begin
					ctrl.jump_kind = JK_REG;
				end else begin
					ctrl.reg_write = 1'b1;
					unique case (funct) inside
						FN_ADD, FN_ADDU: ctrl.alu_op = ALU_ADD;
						FN_SUB, FN_SUBU: ctrl.alu_op = ALU_SUB;
						FN_AND:          ctrl.alu_op = ALU_AND;
						FN_OR:           ctrl.alu_op = ALU_OR;
						FN_XOR:          ctrl.alu_op = ALU_XOR;
						FN_NOR:          ctrl.alu_op = ALU_NOR;
						FN_SLT:          ctrl.alu_op = ALU_SLT;
						FN_SLL:          ctrl.alu_op = ALU_SLL;
						FN_SRL:          ctrl.alu_op = ALU_SRL;
						FN_SRA:          ctrl.alu_op = ALU_SRA;
						default:         ctrl.alu_op = ALU_ZERO;
					endcase
				end
			end
			OP_J: ctrl.jump_kind = JK_ABS;
			OP_JAL: begin
				ctrl.jump_kind   = JK_ABS;
				ctrl.dest_reg    = LINK_REG;
				ctrl.reg_write   = 1'b1;
				ctrl.link_to_reg = 1'b1;
			end
			OP_BEQ, OP_BNE: begin
				ctrl.is_branch = 1'b1;
				ctrl.branch_ne = (op == OP_BNE);
			end
			OP_ADDI, OP_ADDIU: begin
				ctrl.alu_op    = ALU_ADD;
				ctrl.bsel      = BSEL_SIMM;
				ctrl.reg_write = 1'b1;
			end
			OP_SLTI: begin
				ctrl.alu_op    = ALU_SLT;
				ctrl.bsel      = BSEL_SIMM;
				ctrl.reg_write = 1'b1;
			end
			OP_ANDI: begin
				ctrl.alu_op    = ALU_AND;
				ctrl.bsel      = BSEL_ZIMM;
				ctrl.reg_write = 1'b1;
			end
			OP_ORI: begin
				ctrl.alu_op    = ALU_OR;
				ctrl.bsel      = BSEL_ZIMM;
				ctrl.reg_write = 1'b1;
			end
			OP_XORI: begin
				ctrl.alu_op    = ALU_XOR;
				ctrl.bsel      = BSEL_ZIMM;
				ctrl.reg_write = 1'b1;
			end
			OP_LUI: begin
				ctrl.alu_op    = ALU_LUI;
				ctrl.reg_write = 1'b1;
			end
			OP_LW: begin
				ctrl.alu_op     = ALU_ADD;
				ctrl.bsel       = BSEL_SIMM;
				ctrl.reg_write  = 1'b1;
				ctrl.mem_read   = 1'b1;
				ctrl.mem_to_reg = 1'b1;
			end
			OP_SW: begin
				ctrl.alu_op    = ALU_ADD;
				ctrl.bsel      = BSEL_SIMM;
				ctrl.mem_write = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/mdca_execute.sv
module mdca_execute import mdca_pkg::*; (
	input  logic [31:0] instruction,
	input  logic [31:0] rs_value,
	input  logic [31:0] rt_value,
	input  logic [31:0] pc_plus_4,
	input  ctrl_t       ctrl,
	output logic [31:0] alu_result,
	output logic        branch_taken,
	output logic [31:0] target_pc
);

	logic [15:0] imm;
	logic [31:0] simm;
	logic [31:0] zimm;
	logic [31:0] op_b;
	logic [4:0]  shamt;
	logic        equal;

	assign imm   = instruction[15:0];
	assign simm  = {{16{imm[15]}}, imm};
	assign zimm  = {16'h0000, imm};
	assign shamt = instruction[10:6];

	// Second operand select
	always_comb begin
		case (ctrl.bsel)
			BSEL_SIMM: op_b = simm;
			BSEL_ZIMM: op_b = zimm;
			default:   op_b = rt_value;
		endcase
	end

	// ALU; add/sub wrap, no overflow trap
	always_comb begin
		case (ctrl.alu_op)
			ALU_ADD: alu_result = rs_value + op_b;
			ALU_SUB: alu_result = rs_value - op_b;
			ALU_AND: alu_result = rs_value & op_b;
			ALU_OR:  alu_result = rs_value | op_b;
			ALU_XOR: alu_result = rs_value ^ op_b;
			ALU_NOR: alu_result = ~(rs_value | op_b);
			ALU_SLT: alu_result = {31'd0, $signed(rs_value) < $signed(op_b)};
			ALU_SLL: alu_result = rt_value << shamt;
			ALU_SRL: alu_result = rt_value >> shamt;
			ALU_SRA: alu_result = 32'($signed(rt_value) >>> shamt);
			ALU_LUI: alu_result = {imm, 16'h0000};
			default: alu_result = 32'd0;
		endcase
	end

	// Branch condition
	assign equal        = (rs_value == rt_value);
	assign branch_taken = ctrl.is_branch & (equal ^ ctrl.branch_ne);

	// Branch, jump or jr target
	always_comb begin
		if (ctrl.is_branch) begin
			target_pc = pc_plus_4 + {simm[29:0], 2'b00};
		end else begin
			case (ctrl.jump_kind)
				JK_ABS:  target_pc = (pc_plus_4 & REGION_MASK)
					| {4'h0, instruction[25:0], 2'b00};
				JK_REG:  target_pc = rs_value;
				default: target_pc = 32'd0;
			endcase
		end
	end

endmodule

FILE: rtl/mips_decode_control_alu_unit.sv
// Channel | Handshake                   | Payload
// --------+-----------------------------+---------------------------------------------
// input   | in_valid / in_stall          | instruction, rs_value, rt_value, pc_plus_4
// output  | out_valid / out_stall        | alu_result ... link_to_reg (one per input)
//
// One transaction per clock cycle sustained while out_stall is low; the result is
// offered once the input has passed the input register, then the result register.
// Input register feeds decode and ALU logic, which feeds the result register.
// in_stall rises only when both stages are full and the output is stalled.
// arst_n clears the two stage valid flags; payload registers are not reset.
module mips_decode_control_alu_unit import mdca_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        instruction,
	input  logic signed [31:0] rs_value,
	input  logic signed [31:0] rt_value,
	input  logic [31:0]        pc_plus_4,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        alu_result,
	output logic               branch_taken,
	output logic               is_branch,
	output logic [1:0]         jump_kind,
	output logic [31:0]        target_pc,
	output logic [4:0]         dest_reg,
	output logic               reg_write,
	output logic               mem_read,
	output logic               mem_write,
	output logic               mem_to_reg,
	output logic               link_to_reg
);

	logic        valid_s1;
	logic [31:0] inst_s1;
	logic [31:0] rs_s1;
	logic [31:0] rt_s1;
	logic [31:0] pc4_s1;
	logic        valid_s2;
	logic [31:0] result_s2;
	logic        taken_s2;
	logic [31:0] target_s2;
	ctrl_t       ctrl_s2;
	logic        free_s1;
	logic        free_s2;
	ctrl_t       ctrl;
	logic [31:0] alu_res;
	logic        br_taken;
	logic [31:0] target;

	// Stage flow control
	assign free_s2  = !valid_s2 || !out_stall;
	assign free_s1  = !valid_s1 || free_s2;
	assign in_stall = !free_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (free_s1) valid_s1 <= in_valid;
			if (free_s2) valid_s2 <= valid_s1;
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (free_s1 && in_valid) begin
			inst_s1 <= instruction;
			rs_s1   <= rs_value;
			rt_s1   <= rt_value;
			pc4_s1  <= pc_plus_4;
		end
	end

	mdca_decoder u_dec (
		.instruction (inst_s1),
		.ctrl        (ctrl)
	);

	mdca_execute u_exe (
		.instruction  (inst_s1),
		.rs_value     (rs_s1),
		.rt_value     (rt_s1),
		.pc_plus_4    (pc4_s1),
		.ctrl         (ctrl),
		.alu_result   (alu_res),
		.branch_taken (br_taken),
		.target_pc    (target)
	);

	// Result register
	always_ff @(posedge clk) begin
		if (free_s2 && valid_s1) begin
			result_s2 <= alu_res;
			taken_s2  <= br_taken;
			target_s2 <= target;
			ctrl_s2   <= ctrl;
		end
	end

	assign out_valid    = valid_s2;
	assign alu_result   = result_s2;
	assign branch_taken = taken_s2;
	assign is_branch    = ctrl_s2.is_branch;
	assign jump_kind    = ctrl_s2.jump_kind;
	assign target_pc    = target_s2;
	assign dest_reg     = ctrl_s2.dest_reg;
	assign reg_write    = ctrl_s2.reg_write;
	assign mem_read     = ctrl_s2.mem_read;
	assign mem_write    = ctrl_s2.mem_write;
	assign mem_to_reg   = ctrl_s2.mem_to_reg;
	assign link_to_reg  = ctrl_s2.link_to_reg;

endmodule

FILE: rtl/mdca_checker.sv
module mdca_checker import mdca_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [31:0]        alu_result,
	input logic               branch_taken,
	input logic               is_branch,
	input logic [1:0]         jump_kind,
	input logic [4:0]         dest_reg,
	input logic               reg_write,
	input logic               mem_read,
	input logic               mem_write,
	input logic               mem_to_reg,
	input logic               link_to_reg
);

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// Input backpressure only comes from a stalled, full output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// Jumps and branches carry no ALU result
	a_ctl_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (is_branch || jump_kind != JK_NONE) |-> alu_result == 32'd0)
		else $error("nonzero ALU result on control transfer");

	// Link write goes to r31 through an absolute jump
	a_link: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && link_to_reg |-> dest_reg == LINK_REG && reg_write
			&& jump_kind == JK_ABS && !mem_read && !mem_write)
		else $error("inconsistent link write");

	// Taken only on branches; store never writes a register
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!branch_taken || is_branch) && !(mem_write && reg_write)
			&& (mem_to_reg == mem_read))
		else $error("inconsistent control flags");

endmodule

bind mips_decode_control_alu_unit mdca_checker u_mdca_checker (.*);
